FILE: sv/ssr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants of the stream substring replacer
// Word structs, configuration struct, register indexes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int MAX_TARGET_LEN_DEF  = 8;
	localparam int MAX_REPLACE_LEN_DEF = 8;
	localparam int LEN_W               = 4;
	localparam int CFG_DATA_W          = 64;
	localparam int CFG_ADDR_W          = 5;

	typedef enum logic [1:0] {
		REG_TARGET_BYTES      = 2'd0,
		REG_TARGET_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES = 2'd2,
		REG_REPLACEMENT_LEN   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_end;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_char_valid;
		logic       out_end;
	} out_word_t;

	typedef struct packed {
		logic [63:0]      target_bytes;
		logic [LEN_W-1:0] target_length;
		logic [63:0]      replacement_bytes;
		logic [LEN_W-1:0] replacement_length;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_REL,
		ST_REPL,
		ST_FLUSH,
		ST_MARK
	} state_t;

	typedef enum logic [1:0] {
		SRC_WINDOW,
		SRC_REPL,
		SRC_MARK
	} emit_src_t;

	typedef struct packed {
		logic      append;
		logic      pop;
		logic      clear_count;
		logic      idx_clear;
		logic      idx_inc;
		logic      emit;
		emit_src_t emit_sel;
		logic      emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic match;
		logic rel_cond;
		logic count_zero;
		logic count_one;
		logic idx_last;
		logic rl_zero;
		logic end_flag;
		logic emitted;
		logic emit_ok;
	} dp_stat_t;

endpackage

FILE: sv/ssr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_cfg_regs: configuration register file
// APB-style write and read of target and replacement strings and lengths.
// ----------------------------------------------------------------------------
module ssr_cfg_regs import ssr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TARGET_BYTES:      cfg_q.target_bytes       <= pwdata;
				REG_TARGET_LENGTH:     cfg_q.target_length      <= pwdata[LEN_W-1:0];
				REG_REPLACEMENT_BYTES: cfg_q.replacement_bytes  <= pwdata;
				REG_REPLACEMENT_LEN:   cfg_q.replacement_length <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TARGET_BYTES:      prdata = cfg_q.target_bytes;
			REG_TARGET_LENGTH:     prdata = CFG_DATA_W'(cfg_q.target_length);
			REG_REPLACEMENT_BYTES: prdata = cfg_q.replacement_bytes;
			REG_REPLACEMENT_LEN:   prdata = CFG_DATA_W'(cfg_q.replacement_length);
			default:               prdata = '0;
		endcase
	end

endmodule

FILE: sv/ssr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_dpath: pending window, replacement index and output register
// Executes controller commands and reports match and release conditions.
// ----------------------------------------------------------------------------
module ssr_dpath import ssr_pkg::*; #(
	parameter int MAX_TARGET_LEN  = MAX_TARGET_LEN_DEF,
	parameter int MAX_REPLACE_LEN = MAX_REPLACE_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_word_t  in_data,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	input  logic      out_stall,
	output logic      out_valid,
	output out_word_t out_data
);

	localparam int CW  = $clog2(MAX_TARGET_LEN + 1);
	localparam int RIW = (MAX_REPLACE_LEN > 1) ? $clog2(MAX_REPLACE_LEN) : 1;

	logic [7:0]       win_q [MAX_TARGET_LEN];
	logic [CW-1:0]    count_q;
	logic [RIW-1:0]   idx_q;
	logic             end_q;
	logic             emitted_q;
	logic             out_valid_q;
	out_word_t        out_q;

	logic [CW-1:0]    tl_eff;
	logic [LEN_W-1:0] rl_eff;
	logic             pfx;
	logic [7:0]       repl_byte;
	out_word_t        emit_word;

	always_comb begin
		if (cfg.target_length > LEN_W'(MAX_TARGET_LEN)) begin
			tl_eff = CW'(MAX_TARGET_LEN);
		end else begin
			tl_eff = CW'(cfg.target_length);
		end
		if (cfg.replacement_length > LEN_W'(MAX_REPLACE_LEN)) begin
			rl_eff = LEN_W'(MAX_REPLACE_LEN);
		end else begin
			rl_eff = cfg.replacement_length;
		end
	end

	// window entries below the count must equal the leading target bytes
	always_comb begin
		pfx = 1'b1;
		for (int k = 0; k < MAX_TARGET_LEN; k++) begin
			if ((CW'(k) < count_q) && (win_q[k] != cfg.target_bytes[8*k +: 8])) begin
				pfx = 1'b0;
			end
		end
	end

	always_comb begin
		repl_byte = '0;
		for (int k = 0; k < MAX_REPLACE_LEN; k++) begin
			if (idx_q == RIW'(k)) begin
				repl_byte = cfg.replacement_bytes[8*k +: 8];
			end
		end
	end

	always_comb begin
		stat.match      = (tl_eff != '0) && (count_q == tl_eff) && pfx;
		stat.rel_cond   = (count_q != '0) && ((count_q >= tl_eff) || !pfx);
		stat.count_zero = (count_q == '0);
		stat.count_one  = (count_q == CW'(1));
		stat.idx_last   = ((LEN_W'(idx_q) + LEN_W'(1)) == rl_eff);
		stat.rl_zero    = (rl_eff == '0);
		stat.end_flag   = end_q;
		stat.emitted    = emitted_q;
		stat.emit_ok    = !out_valid_q || !out_stall;
	end

	always_comb begin
		emit_word.out_end = cmd.emit_last;
		case (cmd.emit_sel)
			SRC_WINDOW: begin
				emit_word.out_char       = win_q[0];
				emit_word.out_char_valid = 1'b1;
			end
			SRC_REPL: begin
				emit_word.out_char       = repl_byte;
				emit_word.out_char_valid = 1'b1;
			end
			SRC_MARK: begin
				emit_word.out_char       = '0;
				emit_word.out_char_valid = 1'b0;
			end
			default: begin
				emit_word.out_char       = '0;
				emit_word.out_char_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			end_q       <= 1'b0;
			emitted_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				count_q   <= count_q + CW'(1);
				end_q     <= in_data.in_end;
				emitted_q <= 1'b0;
			end else if (cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.idx_clear) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + RIW'(1);
			end
			if (cmd.emit) begin
				emitted_q   <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			for (int k = 0; k < MAX_TARGET_LEN; k++) begin
				if (count_q == CW'(k)) begin
					win_q[k] <= in_data.in_char;
				end
			end
		end else if (cmd.pop) begin
			for (int k = 0; k < MAX_TARGET_LEN - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
		end
		if (cmd.emit) begin
			out_q <= emit_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sv/ssr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_ctrl: sequencing state machine
// Accepts one input word, then walks match, release, replacement, flush and end marker.
// ----------------------------------------------------------------------------
module ssr_ctrl import ssr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t st_q;
	state_t st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) st_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (stat.match) begin
					if (!stat.rl_zero) st_d = ST_REPL;
					else if (stat.end_flag) st_d = ST_MARK;
					else st_d = ST_IDLE;
				end else begin
					st_d = ST_REL;
				end
			end
			ST_REL: begin
				if (!stat.rel_cond) begin
					if (!stat.end_flag) st_d = ST_IDLE;
					else if (!stat.count_zero) st_d = ST_FLUSH;
					else if (!stat.emitted) st_d = ST_MARK;
					else st_d = ST_IDLE;
				end
			end
			ST_REPL: begin
				if (stat.emit_ok && stat.idx_last) st_d = ST_IDLE;
			end
			ST_FLUSH: begin
				if (stat.emit_ok && stat.count_one) st_d = ST_IDLE;
			end
			ST_MARK: begin
				if (stat.emit_ok) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.emit_sel = SRC_WINDOW;
		in_stall     = (st_q != ST_IDLE);
		case (st_q)
			ST_IDLE: begin
				cmd.append = in_valid;
			end
			ST_EVAL: begin
				if (stat.match) begin
					cmd.clear_count = 1'b1;
					cmd.idx_clear   = 1'b1;
				end
			end
			ST_REL: begin
				if (stat.rel_cond && stat.emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = SRC_WINDOW;
					cmd.emit_last = stat.end_flag && stat.count_one;
					cmd.pop       = 1'b1;
				end
			end
			ST_REPL: begin
				if (stat.emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = SRC_REPL;
					cmd.emit_last = stat.end_flag && stat.idx_last;
					cmd.idx_inc   = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (stat.emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = SRC_WINDOW;
					cmd.emit_last = stat.count_one;
					cmd.pop       = 1'b1;
				end
			end
			ST_MARK: begin
				if (stat.emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = SRC_MARK;
					cmd.emit_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/stream_substring_replacer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_substring_replacer: streaming find and replace over a byte stream
// Replaces every leftmost, non-overlapping occurrence of a target string of up
// to MAX_TARGET_LEN bytes with a replacement of up to MAX_REPLACE_LEN bytes.
//
// Usage:
//   Input words (in_char, in_end) arrive on in_valid / in_stall; in_end marks
//   the last byte of a string. Output words (out_char, out_char_valid,
//   out_end) leave on out_valid / out_stall; out_end marks the last word of the
//   rewritten string, and a word with out_char_valid low is a bare end marker.
//   Program the four registers over the APB port (8-byte spacing) while idle.
//   Throughput: one input word at a time. A byte that completes a match is
//   followed by its R replacement bytes, or by a bare end marker at end of
//   string when R is zero; any other byte is followed by the N bytes that it
//   releases or flushes. The release and flush loop pops one window byte per
//   cycle, the replacement one byte per cycle from the configuration register,
//   each while the output is not stalled.
//   Reset clears the window count, the sequencer, flags and config registers;
//   the window bytes and output word are not cleared. A stall on the output
//   holds the output register and the emitting states until the word is taken.
// ----------------------------------------------------------------------------
module stream_substring_replacer import ssr_pkg::*; #(
	parameter int MAX_TARGET_LEN  = MAX_TARGET_LEN_DEF,
	parameter int MAX_REPLACE_LEN = MAX_REPLACE_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// input stream
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_data,
	// output stream
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_data
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// register file: target and replacement strings and their lengths
	ssr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: accept, evaluate, release, replace, flush, end marker
	ssr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// window, replacement index and output register
	ssr_dpath #(
		.MAX_TARGET_LEN  (MAX_TARGET_LEN),
		.MAX_REPLACE_LEN (MAX_REPLACE_LEN)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
